### rtl/ccprr_pkg.sv
// Shared constants, types and helper functions for the CRC-checked request packet receiver.
package ccprr_pkg;

  // Payload store
  localparam int BUFFER_DEPTH = 128;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = 7;

  // CRC16-CCITT
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Framing bytes
  localparam logic [7:0] HDR_LOC      = 8'hAA;
  localparam logic [7:0] HDR_MAP      = 8'hA5;
  localparam logic [7:0] HDR_ANG      = 8'h5A;
  localparam logic [7:0] TX_MAP       = 8'hBB;
  localparam logic [7:0] TX_ANG       = 8'hFE;
  localparam logic [7:0] MAP_LEN_BYTE = 8'd64;

  // Bytes collected after the header, CRC included
  localparam logic [CNT_W-1:0] LEN_LOC = 7'd10;
  localparam logic [CNT_W-1:0] LEN_MAP = 7'd67;
  localparam logic [CNT_W-1:0] LEN_ANG = 7'd6;

  localparam logic [5:0] MAP_LAST = 6'd63;

  typedef enum logic [1:0] {
    CMD_REQ  = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LOC  = 2'd0,
    KIND_MAP  = 2'd1,
    KIND_ANG  = 2'd2,
    KIND_IDLE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EV_REQ = 2'd0,
    EV_LOC = 2'd1,
    EV_MAP = 2'd2,
    EV_ANG = 2'd3
  } event_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  tx_byte;
    logic [31:0] word_first;
    logic [31:0] word_second;
    logic [5:0]  map_index;
    logic [2:0]  cell_high;
    logic [2:0]  cell_mid;
    logic [2:0]  cell_low;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [2:0] high;
    logic [2:0] mid;
    logic [2:0] low;
  } cells_t;

  // Controller to datapath
  typedef struct packed {
    logic       take;
    logic       map_rd;
    logic       map_load;
    logic [5:0] map_idx;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic map_start;
  } dp_stat_t;

  // One byte of CRC16-CCITT, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    int          k;
    c = c_in ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] hdr_of(input kind_t k);
    logic [7:0] h;
    case (k)
      KIND_LOC: h = HDR_LOC;
      KIND_MAP: h = HDR_MAP;
      KIND_ANG: h = HDR_ANG;
      default:  h = HDR_LOC;
    endcase
    return h;
  endfunction

  function automatic logic [CNT_W-1:0] len_of(input kind_t k);
    logic [CNT_W-1:0] l;
    case (k)
      KIND_LOC: l = LEN_LOC;
      KIND_MAP: l = LEN_MAP;
      KIND_ANG: l = LEN_ANG;
      default:  l = LEN_LOC;
    endcase
    return l;
  endfunction

  // Base-6 split of a compressed map byte: v/36, (v%36)/6, v%6 by reciprocal multiplies
  function automatic cells_t map_cells(input logic [7:0] v);
    logic [11:0] p_hi;
    logic [7:0]  r8;
    logic [5:0]  r;
    logic [10:0] p_mid;
    logic [5:0]  lo6;
    cells_t      c;
    p_hi   = 12'(v[7:2]) * 12'd57;
    c.high = p_hi[11:9];
    r8     = v - (8'(c.high) * 8'd36);
    r      = r8[5:0];
    p_mid  = 11'(r) * 11'd43;
    c.mid  = p_mid[10:8];
    lo6    = r - (6'(c.mid) * 6'd6);
    c.low  = lo6[2:0];
    return c;
  endfunction

endpackage

### rtl/ccprr_item_if.sv
// Input and result channel interfaces for the CRC-checked request packet receiver.
interface ccprr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] req_kind;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output req_kind, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input req_kind, input rx_byte, output ready);
endinterface

interface ccprr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  tx_byte;
  logic [31:0] word_first;
  logic [31:0] word_second;
  logic [5:0]  map_index;
  logic [2:0]  cell_high;
  logic [2:0]  cell_mid;
  logic [2:0]  cell_low;
  logic        last;

  modport source (output valid, output event_res, output tx_byte, output word_first,
                  output word_second, output map_index, output cell_high, output cell_mid,
                  output cell_low, output last, input ready);
  modport sink   (input valid, input event_res, input tx_byte, input word_first,
                  input word_second, input map_index, input cell_high, input cell_mid,
                  input cell_low, input last, output ready);
endinterface

### rtl/ccprr_ctrl.sv
// Controller: input acceptance and the walk over the stored map bytes.
module ccprr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  ccprr_pkg::dp_stat_t stat,
  output ccprr_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_ITEM,
    S_MAP_RD,
    S_MAP_OUT
  } state_t;

  state_t     state;
  logic [5:0] idx;

  // Items only in S_ITEM and only when the output register can take a result
  assign item_ready = (state == S_ITEM) && stat.out_free;

  always_comb begin
    cmd.take     = item_valid && item_ready;
    cmd.map_rd   = (state == S_MAP_RD);
    cmd.map_load = (state == S_MAP_OUT) && stat.out_free;
    cmd.map_idx  = idx;
  end

  // State register: a read state, then an output state for each triple
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ITEM;
      idx   <= '0;
    end else begin
      case (state)
        S_ITEM: begin
          if (cmd.take && stat.map_start) begin
            state <= S_MAP_RD;
            idx   <= '0;
          end
        end
        S_MAP_RD: begin
          state <= S_MAP_OUT;
        end
        S_MAP_OUT: begin
          if (stat.out_free) begin
            if (idx == ccprr_pkg::MAP_LAST) begin
              state <= S_ITEM;
            end else begin
              idx   <= idx + 6'd1;
              state <= S_MAP_RD;
            end
          end
        end
        default: begin
          state <= S_ITEM;
        end
      endcase
    end
  end

endmodule

### rtl/ccprr_dp.sv
// Datapath: receiver state, running CRC, payload store and output register.
module ccprr_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic [1:0]          item_cmd,
  input  logic [7:0]          item_req_kind,
  input  logic [7:0]          item_rx_byte,
  input  logic                result_ready,
  output logic                result_valid,
  output ccprr_pkg::res_t     result_data,
  input  ccprr_pkg::dp_cmd_t  cmd,
  output ccprr_pkg::dp_stat_t stat
);

  localparam int ADDR_W = ccprr_pkg::ADDR_W;
  localparam int CNT_W  = ccprr_pkg::CNT_W;

  // Registers
  logic [7:0]              timeout_limit;
  ccprr_pkg::kind_t        wanted, wanted_next;
  logic                    collecting, collecting_next;
  logic [CNT_W-1:0]        byte_count, byte_count_next;
  logic [7:0]              quiet, quiet_next;
  logic [15:0]             crc, crc_next;
  logic [7:0]              crc_hi, crc_hi_next;
  logic                    len_ok, len_ok_next;
  logic [63:0]             words, words_next;
  ccprr_pkg::res_t         res_q, res_next;
  logic                    res_valid, res_valid_next;
  logic [7:0]              mem [ccprr_pkg::BUFFER_DEPTH];
  logic [7:0]              mem_q;

  // Decode helpers
  logic                    mem_we;
  logic                    clear;
  logic                    send_req;
  ccprr_pkg::kind_t        req_sel;
  logic                    load;
  logic                    map_start;
  logic [7:0]              q_inc;
  logic [CNT_W-1:0]        pkt_len;
  logic [7:0]              hdr;
  logic [ADDR_W-1:0]       rd_addr;
  ccprr_pkg::cells_t       cells;

  assign stat.out_free  = !res_valid || result_ready;
  assign stat.map_start = map_start;
  assign result_valid   = res_valid;
  assign result_data    = res_q;

  assign rd_addr = ADDR_W'({1'b0, cmd.map_idx} + 7'd1);
  assign cells   = ccprr_pkg::map_cells(mem_q);

  // Per-item processing
  always_comb begin
    wanted_next     = wanted;
    collecting_next = collecting;
    byte_count_next = byte_count;
    quiet_next      = quiet;
    crc_next        = crc;
    crc_hi_next     = crc_hi;
    len_ok_next     = len_ok;
    words_next      = words;
    res_next        = res_q;
    mem_we          = 1'b0;
    clear           = 1'b0;
    send_req        = 1'b0;
    req_sel         = wanted;
    load            = 1'b0;
    map_start       = 1'b0;
    q_inc           = quiet + 8'd1;
    pkt_len         = ccprr_pkg::len_of(wanted);
    hdr             = ccprr_pkg::hdr_of(wanted);

    if (cmd.take) begin
      case (ccprr_pkg::cmd_t'(item_cmd))
        ccprr_pkg::CMD_REQ: begin
          if (wanted == ccprr_pkg::KIND_IDLE) begin
            clear = 1'b1;
            if (item_req_kind <= 8'd2) begin
              wanted_next = ccprr_pkg::kind_t'(item_req_kind[1:0]);
              req_sel     = ccprr_pkg::kind_t'(item_req_kind[1:0]);
              send_req    = 1'b1;
            end
          end
        end
        ccprr_pkg::CMD_BYTE: begin
          if (wanted != ccprr_pkg::KIND_IDLE) begin
            quiet_next = '0;
            if (!collecting) begin
              // hunting for the header
              if (item_rx_byte == hdr) begin
                collecting_next = 1'b1;
                byte_count_next = '0;
                crc_next        = ccprr_pkg::crc_step(ccprr_pkg::CRC_INIT, hdr);
              end
            end else begin
              mem_we          = 1'b1;
              byte_count_next = byte_count + 7'd1;
              if (byte_count < (pkt_len - 7'd2)) begin
                crc_next = ccprr_pkg::crc_step(crc, item_rx_byte);
              end
              if (byte_count == (pkt_len - 7'd2)) begin
                crc_hi_next = item_rx_byte;
              end
              if (byte_count == '0) begin
                len_ok_next = (item_rx_byte == ccprr_pkg::MAP_LEN_BYTE);
              end
              if (byte_count < 7'd8) begin
                words_next[{byte_count[2:0], 3'b000} +: 8] = item_rx_byte;
              end
              // final CRC byte: check and deliver
              if (byte_count == (pkt_len - 7'd1)) begin
                clear = 1'b1;
                if (({crc_hi, item_rx_byte} == crc) &&
                    ((wanted != ccprr_pkg::KIND_MAP) || len_ok)) begin
                  wanted_next = ccprr_pkg::KIND_IDLE;
                  case (wanted)
                    ccprr_pkg::KIND_LOC: begin
                      load                 = 1'b1;
                      res_next             = '0;
                      res_next.event_res   = ccprr_pkg::EV_LOC;
                      res_next.word_first  = words[31:0];
                      res_next.word_second = words[63:32];
                      res_next.last        = 1'b1;
                    end
                    ccprr_pkg::KIND_ANG: begin
                      load                = 1'b1;
                      res_next            = '0;
                      res_next.event_res  = ccprr_pkg::EV_ANG;
                      res_next.word_first = words[31:0];
                      res_next.last       = 1'b1;
                    end
                    ccprr_pkg::KIND_MAP: begin
                      map_start = 1'b1;
                    end
                    default: begin
                      map_start = 1'b0;
                    end
                  endcase
                end else begin
                  send_req = 1'b1;
                end
              end
            end
          end
        end
        ccprr_pkg::CMD_TICK: begin
          if ((wanted != ccprr_pkg::KIND_IDLE) && collecting) begin
            if (q_inc >= timeout_limit) begin
              clear    = 1'b1;
              send_req = 1'b1;
            end else begin
              quiet_next = q_inc;
            end
          end else begin
            quiet_next = '0;
          end
        end
        default: begin
          clear = 1'b0;
        end
      endcase

      // Receiver reset
      if (clear) begin
        collecting_next = 1'b0;
        byte_count_next = '0;
        quiet_next      = '0;
      end

      // Request byte for map and angle
      if (send_req && (req_sel == ccprr_pkg::KIND_MAP || req_sel == ccprr_pkg::KIND_ANG)) begin
        load               = 1'b1;
        res_next           = '0;
        res_next.event_res = ccprr_pkg::EV_REQ;
        res_next.tx_byte   = (req_sel == ccprr_pkg::KIND_MAP) ? ccprr_pkg::TX_MAP
                                                              : ccprr_pkg::TX_ANG;
        res_next.last      = 1'b1;
      end
    end

    // Map triple from the registered store read
    if (cmd.map_load) begin
      load               = 1'b1;
      res_next           = '0;
      res_next.event_res = ccprr_pkg::EV_MAP;
      res_next.map_index = cmd.map_idx;
      res_next.cell_high = cells.high;
      res_next.cell_mid  = cells.mid;
      res_next.cell_low  = cells.low;
      res_next.last      = (cmd.map_idx == ccprr_pkg::MAP_LAST);
    end

    if (load) begin
      res_valid_next = 1'b1;
    end else if (result_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= 8'd3;
      wanted        <= ccprr_pkg::KIND_IDLE;
      collecting    <= 1'b0;
      byte_count    <= '0;
      quiet         <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_limit <= cfg_wr_data;
      end
      wanted     <= wanted_next;
      collecting <= collecting_next;
      byte_count <= byte_count_next;
      quiet      <= quiet_next;
      res_valid  <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    crc    <= crc_next;
    crc_hi <= crc_hi_next;
    len_ok <= len_ok_next;
    words  <= words_next;
    res_q  <= res_next;
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ADDR_W'(byte_count)] <= item_rx_byte;
    end
    if (cmd.map_rd) begin
      mem_q <= mem[rd_addr];
    end
  end

endmodule

### rtl/crc_checked_request_packet_receiver.sv
// Top level of the CRC-checked request packet receiver.
// A request, a received byte or a timer tick is taken whenever the output register is
// empty or being emptied, so ordinary items run at one per cycle and a request byte,
// location or angle result is presented the cycle after its item. A good map packet is
// then expanded from the byte store into its 64 triples, each by a registered memory
// read and then an output load; no item is taken while this runs. The store is not
// cleared after reset; every byte read has been written by the current packet.
// timeout_limit resets to 3.
module crc_checked_request_packet_receiver (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  ccprr_item_if.sink            item,
  ccprr_result_if.source        result
);

  ccprr_pkg::dp_cmd_t  dp_cmd;
  ccprr_pkg::dp_stat_t dp_stat;
  ccprr_pkg::res_t     res_data;
  logic                item_ready;
  logic                res_valid;

  ccprr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  ccprr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .item_cmd      (item.cmd),
    .item_req_kind (item.req_kind),
    .item_rx_byte  (item.rx_byte),
    .result_ready  (result.ready),
    .result_valid  (res_valid),
    .result_data   (res_data),
    .cmd           (dp_cmd),
    .stat          (dp_stat)
  );

  // Channel wiring
  assign item.ready         = item_ready;
  assign result.valid       = res_valid;
  assign result.event_res   = res_data.event_res;
  assign result.tx_byte     = res_data.tx_byte;
  assign result.word_first  = res_data.word_first;
  assign result.word_second = res_data.word_second;
  assign result.map_index   = res_data.map_index;
  assign result.cell_high   = res_data.cell_high;
  assign result.cell_mid    = res_data.cell_mid;
  assign result.cell_low    = res_data.cell_low;
  assign result.last        = res_data.last;

endmodule

### rtl/ccprr_checker.sv
// Port-level assertions for the CRC-checked request packet receiver, with its bind.
module ccprr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_event,
  input logic [7:0] out_tx,
  input logic       out_last
);

  // A held result keeps its event code
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_event))
    else $error("result changed while stalled");

  // An item is only taken when the output register can receive its result
  a_in_vs_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("transaction taken while output blocked");

  // Request transactions carry one of the two request bytes
  a_req_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event == ccprr_pkg::EV_REQ |->
      out_tx == ccprr_pkg::TX_MAP || out_tx == ccprr_pkg::TX_ANG)
    else $error("bad request byte");

  // Single results always close their item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event != ccprr_pkg::EV_MAP |-> out_last)
    else $error("single result without last");

  // Payload results send no transmit byte
  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event != ccprr_pkg::EV_REQ |-> out_tx == 8'd0)
    else $error("tx byte on payload result");

endmodule

bind crc_checked_request_packet_receiver ccprr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_event (result.event_res),
  .out_tx    (result.tx_byte),
  .out_last  (result.last)
);
